### rtl/iss_pkg.sv
// Shared constants, codes and types of the indexed sequence store.
`default_nettype none
package iss_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STAT_W   = 2;
  // Wide enough for both a position magnitude and the entry count.
  localparam int unsigned CMP_W    = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS    = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic  ins;
    logic  del;
    idx_t  where;
    data_t value;
    logic  rd_en;
    idx_t  rd_pos;
  } cell_ctrl_t;

  typedef struct packed {
    cell_ctrl_t        ctrl;
    logic              rd_miss;
    logic [STAT_W-1:0] status;
    cnt_t              count_d;
  } dec_t;

endpackage
`default_nettype wire

### rtl/iss_req_if.sv
// Request channel of the indexed sequence store: opcode, position and value.
`default_nettype none
interface iss_req_if;
  import iss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, opcode, position, value_in, input ready);
  modport sink   (input valid, opcode, position, value_in, output ready);
endinterface
`default_nettype wire

### rtl/iss_rsp_if.sv
// Response channel of the indexed sequence store: read value, status, count.
`default_nettype none
interface iss_rsp_if;
  import iss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

### rtl/iss_decode.sv
// Operation decode: range checks, insert/delete point and next entry count.
`default_nettype none
module iss_decode (
  input  wire logic                       go_i,
  input  wire logic [iss_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [iss_pkg::POS_W-1:0]  position_i,
  input  wire logic [iss_pkg::DATA_W-1:0] value_i,
  input  wire logic [iss_pkg::CNT_W-1:0]  count_i,
  output iss_pkg::dec_t                   dec_o
);
  import iss_pkg::*;

  logic             pos_neg;
  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] clamped;
  logic             in_range;
  logic             full;

  assign pos_neg  = position_i[POS_W-1];
  assign pos_u    = CMP_W'(position_i[POS_W-2:0]);
  assign cnt_ext  = CMP_W'(count_i);
  assign in_range = !pos_neg && (pos_u < cnt_ext);
  assign full     = (count_i == CNT_W'(CAPACITY));
  assign clamped  = pos_neg ? '0 : pos_u;

  always_comb begin
    dec_o              = '0;
    dec_o.ctrl.value   = value_i;
    dec_o.ctrl.rd_pos  = IDX_W'(pos_u);
    dec_o.count_d      = count_i;
    dec_o.status       = ST_DONE;
    unique case (opcode_i)
      OP_READ: begin
        if (in_range) begin
          dec_o.ctrl.rd_en = 1'b1;
        end else begin
          dec_o.rd_miss = 1'b1;
          dec_o.status  = ST_OUT_RANGE;
        end
      end
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (full) begin
          dec_o.status = ST_FULL;
        end else begin
          dec_o.ctrl.ins   = go_i;
          dec_o.ctrl.where = (opcode_i == OP_INS_HEAD) ? '0 : IDX_W'(count_i);
          dec_o.count_d    = count_i + CNT_W'(1);
        end
      end
      OP_INS_POS: begin
        if (clamped > cnt_ext) begin
          dec_o.status = ST_OUT_RANGE;
        end else if (full) begin
          dec_o.status = ST_FULL;
        end else begin
          dec_o.ctrl.ins   = go_i;
          dec_o.ctrl.where = IDX_W'(clamped);
          dec_o.count_d    = count_i + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          dec_o.ctrl.del   = go_i;
          dec_o.ctrl.where = IDX_W'(pos_u);
          dec_o.count_d    = count_i - CNT_W'(1);
        end else begin
          dec_o.status = ST_OUT_RANGE;
        end
      end
      default: begin
        dec_o.status = ST_OUT_RANGE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/iss_cell.sv
// One storage cell of the row: holds an entry and shifts with its neighbors.
`default_nettype none
module iss_cell (
  input  wire logic                       clk_i,
  input  wire iss_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [iss_pkg::IDX_W-1:0]  idx_i,
  input  wire logic [iss_pkg::DATA_W-1:0] lower_i,
  input  wire logic [iss_pkg::DATA_W-1:0] upper_i,
  output logic [iss_pkg::DATA_W-1:0]      entry_o,
  output logic [iss_pkg::DATA_W-1:0]      rd_o
);
  import iss_pkg::*;

  data_t entry_q;
  data_t entry_d;

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins && (idx_i > ctrl_i.where)) begin
      entry_d = lower_i;
    end else if (ctrl_i.ins && (idx_i == ctrl_i.where)) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.del && (idx_i >= ctrl_i.where)) begin
      entry_d = upper_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Drive the shared read bus only when addressed.
  assign rd_o = (ctrl_i.rd_en && (idx_i == ctrl_i.rd_pos)) ? entry_q : '0;

endmodule
`default_nettype wire

### rtl/indexed_sequence_store_unit.sv
// Top level of the indexed sequence store: cell row, decode and response register.
//
// Usage:
//   req_i carries one operation per beat: opcode, signed position, value_in.
//   rsp_o returns one beat per operation: read_value, status, entry_count.
//   Opcodes: read, insert at head, insert at tail, insert at position,
//   delete at position. Inserts shift later entries up one cell, deletes
//   shift them down; all cells that shift move in the same cycle.
// Latency: the response is valid the cycle after the request beat.
// Throughput: one operation per cycle while rsp_o is taken; the row of cells
//   does the whole shift at once, and the next operation sees the new count.
// Stall: when rsp_o is not taken, the response register holds and
//   req_i.ready drops until it drains; nothing is lost or repeated.
// Reset: count clears to zero and the response register empties; the cell
//   contents are not cleared, since only cells below the count are read.
`default_nettype none
module indexed_sequence_store_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iss_req_if.sink   req_i,
  iss_rsp_if.source rsp_o
);
  import iss_pkg::*;

  cnt_t              count_q;
  logic              accept;
  dec_t              dec;
  data_t             entries [CAPACITY];
  data_t             rd_bus  [CAPACITY];
  data_t             rd_or;
  data_t             read_value_d;

  logic              out_valid_q;
  data_t             read_value_q;
  logic [STAT_W-1:0] status_q;
  cnt_t              entry_count_q;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  iss_decode u_decode (
    .go_i       (accept),
    .opcode_i   (req_i.opcode),
    .position_i (req_i.position),
    .value_i    (req_i.value_in),
    .count_i    (count_q),
    .dec_o      (dec)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t lower;
    data_t upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entries[g+1];
    end
    iss_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (dec.ctrl),
      .idx_i   (IDX_W'(g)),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entries[g]),
      .rd_o    (rd_bus[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_bus[i];
    end
  end

  always_comb begin
    priority if (dec.ctrl.rd_en) begin
      read_value_d = rd_or;
    end else if (dec.rd_miss) begin
      read_value_d = '1;
    end else begin
      read_value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= dec.count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q  <= read_value_d;
      status_q      <= dec.status;
      entry_count_q <= dec.count_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = read_value_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = entry_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (dec.status == ST_FULL) |=> count_q == $past(count_q))
    else $error("refused insert changed the count");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec.ctrl.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_delete_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec.ctrl.del |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("delete did not shrink the count");

  a_rsp_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> entry_count_q == count_q)
    else $error("reported count differs from held count");

endmodule
`default_nettype wire
